[sv/izh_pkg.sv]
// Package for the Izhikevich neuron update pipeline.
// Shared types, fixed-point constants and the saturation helper; no dependencies.
`default_nettype none
package izh_pkg;

  // Euler substeps per time step; the divide by SUBSTEPS is a rounding shift,
  // so this must stay a power of two
  localparam int SUBSTEPS = 4;
  localparam int SUB_SH   = $clog2(SUBSTEPS);

  localparam int IN_DATA_W  = 360;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_ADDR_W = 3;

  localparam logic [4:0] CUR_FRAC_RESET = 5'd20;

  typedef enum logic [0:0] {
    REG_CUR_FRAC = 1'b0
  } cfg_reg_t;

  localparam logic signed [31:0] QMAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] QMIN = 32'sh8000_0000;
  localparam logic signed [31:0] V_TH = 32'sd1966080;   // 30.0
  localparam logic signed [36:0] V_CONST = 37'sd9175040; // 140.0

  // floor(x/25) by reciprocal, exact for the operand ranges used
  localparam logic [21:0] RCP25_HI = 22'd2684355;   // ceil(2^26/25)
  localparam logic [24:0] RCP25_LO = 25'd21474837;  // ceil(2^29/25)

  typedef struct packed {
    logic signed [31:0] v;
    logic signed [31:0] u;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] cur_i;
    logic               force_fire;
    logic [63:0]        hist;
    logic               fired;
  } nrn_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (&x[65:31] || ~|x[65:31]) r = x[31:0];
    else if (x[65])              r = QMIN;
    else                         r = QMAX;
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/izh_substep.sv]
// One forward Euler substep of the Izhikevich update, eight register stages.
// Depends on izh_pkg.
`default_nettype none
module izh_substep
  import izh_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic in_vld,
  input  nrn_t      in_nrn,
  output logic      out_vld,
  output nrn_t      out_nrn
);

  localparam logic signed [64:0] RND_U = 65'sd1 <<< (15 + SUB_SH);
  localparam logic signed [39:0] RND_V = 40'sd1 <<< SUB_SH >>> 1;

  logic [8:1] vld_r;
  nrn_t       s1_r, s2_r, s3_r, s4_r, s5_r, s6_r, s7_r, s8_r;

  logic [62:0]        sq_r;
  logic signed [36:0] lin1_r, lin2_r, lin3_r;
  logic [15:0]        q1_r, q1b_r;
  logic [19:0]        yh_r;
  logic [18:0]        yl_r;
  logic [19:0]        q2_r;
  logic               ovf2_r, ovf3_r;
  logic               fnew4_r, fnew5_r, fnew6_r, fnew7_r;
  logic signed [63:0] bv_r, aw_r;
  logic signed [31:0] w_r;

  // stage 1: square and linear terms
  logic signed [63:0] sq_nxt;
  logic signed [36:0] lin_nxt;
  assign sq_nxt  = in_nrn.v * in_nrn.v;
  assign lin_nxt = 37'(in_nrn.v) * 37'sd5 + V_CONST - 37'(in_nrn.u) + 37'(in_nrn.cur_i);

  // stage 2: scale square, high digit /25; an oversized square saturates v high
  logic [63:0] ysum;
  logic [46:0] y;
  logic [38:0] yc;
  logic [41:0] p1;
  assign ysum = {1'b0, sq_r} + 64'd819200;
  assign y    = ysum[62:16];
  assign yc   = (|y[46:39]) ? {39{1'b1}} : y[38:0];
  assign p1   = 42'(yc[38:19]) * 42'(RCP25_HI);

  // stage 3: remainder folded into low digit /25
  logic [20:0] r1w;
  logic [23:0] z2;
  logic [48:0] p2;
  assign r1w = 21'(yh_r) - 21'(q1_r) * 21'd25;
  assign z2  = {r1w[4:0], yl_r};
  assign p2  = 49'(z2) * 49'(RCP25_LO);

  // stage 4: new potential
  logic [35:0]        quad;
  logic signed [39:0] s_sum;
  logic signed [40:0] vt;
  logic signed [31:0] vn;
  nrn_t               s4_nxt;
  assign quad  = {1'b0, q1b_r, 19'd0} + 36'(q2_r);
  assign s_sum = $signed({4'd0, quad}) + 40'(lin3_r);
  assign vt    = 41'(s3_r.v) + 41'((s_sum + RND_V) >>> SUB_SH);
  assign vn    = ovf3_r ? QMAX : sat32(66'(vt));

  always_comb begin
    s4_nxt   = s3_r;
    s4_nxt.v = s3_r.fired ? s3_r.v : vn;
  end

  // stage 6: w = b*v - u
  logic signed [64:0] bvr;
  logic signed [31:0] w_nxt;
  assign bvr   = (65'(bv_r) + 65'sd32768) >>> 16;
  assign w_nxt = sat32(66'(bvr) - 66'(s5_r.u));

  // stage 8: new recovery
  logic signed [64:0] awr;
  logic signed [31:0] un;
  nrn_t               s8_nxt;
  assign awr = (65'(aw_r) + RND_U) >>> (16 + SUB_SH);
  assign un  = sat32(66'(awr) + 66'(s7_r.u));

  always_comb begin
    s8_nxt       = s7_r;
    s8_nxt.u     = s7_r.fired ? s7_r.u : un;
    s8_nxt.fired = s7_r.fired | fnew7_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[7:1], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= in_nrn;
      sq_r   <= sq_nxt[62:0];
      lin1_r <= lin_nxt;

      s2_r   <= s1_r;
      lin2_r <= lin1_r;
      yh_r   <= yc[38:19];
      yl_r   <= yc[18:0];
      q1_r   <= p1[41:26];
      ovf2_r <= |y[46:39];

      s3_r   <= s2_r;
      lin3_r <= lin2_r;
      q1b_r  <= q1_r;
      q2_r   <= p2[48:29];
      ovf3_r <= ovf2_r;

      s4_r    <= s4_nxt;
      fnew4_r <= !s3_r.fired && (vn >= V_TH);

      s5_r    <= s4_r;
      fnew5_r <= fnew4_r;
      bv_r    <= s4_r.b * s4_r.v;

      s6_r    <= s5_r;
      fnew6_r <= fnew5_r;
      w_r     <= w_nxt;

      s7_r    <= s6_r;
      fnew7_r <= fnew6_r;
      aw_r    <= s6_r.a * w_r;

      s8_r <= s8_nxt;
    end
  end

  assign out_vld = vld_r[8];
  assign out_nrn = s8_r;

endmodule
`default_nettype wire

[sv/izhikevich_neuron_update_top.sv]
// Izhikevich neuron update: one item per cycle while not stalled, 35 stage pipeline.
// Depends on izh_pkg and izh_substep.
// Accepts one neuron per clock while not stalled and returns its update: two stages
// convert the current and add noise, each of the 4 Euler substeps takes 8 stages
// (three multiplies in series plus a two-digit divide by 25), and one output stage
// applies the spike reset. The whole pipeline holds while out_tready is low with a
// result waiting; in_tready follows that stall.
`default_nettype none
module izhikevich_neuron_update_top
  import izh_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // potential, recovery, recovery_time_scale, recovery_sensitivity, reset_potential,
  // reset_recovery_step, noise_scale, gaussian_sample, input_current (32 each),
  // forced_fire (1), history_in (64), zero pad
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // new_potential (32), new_recovery (32), spiked (1), history_out (64), zero pad
  output logic [OUT_DATA_W-1:0]      out_tdata,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);

  logic       en;
  logic [4:0] cur_frac_r;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_frac_r <= CUR_FRAC_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_CUR_FRAC) begin
      cur_frac_r <= cfg_pwdata[4:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_CUR_FRAC) ? {27'd0, cur_frac_r} : 32'd0;

  // unpack request
  nrn_t               in_nrn;
  logic signed [31:0] sigma, gs;
  assign in_nrn.v          = in_tdata[31:0];
  assign in_nrn.u          = in_tdata[63:32];
  assign in_nrn.a          = in_tdata[95:64];
  assign in_nrn.b          = in_tdata[127:96];
  assign in_nrn.c          = in_tdata[159:128];
  assign in_nrn.d          = in_tdata[191:160];
  assign sigma             = in_tdata[223:192];
  assign gs                = in_tdata[255:224];
  assign in_nrn.cur_i      = in_tdata[287:256];
  assign in_nrn.force_fire = in_tdata[288];
  assign in_nrn.hist       = in_tdata[352:289];
  assign in_nrn.fired      = 1'b0;

  // stage F1: current format conversion, noise product
  logic [4:0]         shl;
  logic [3:0]         shr;
  logic signed [63:0] cur_up;
  logic signed [32:0] cur_dn;
  logic signed [31:0] cur_nxt;
  always_comb begin
    shl    = 5'd16 - cur_frac_r;
    shr    = 4'(cur_frac_r - 5'd16);
    cur_up = 64'(in_nrn.cur_i) <<< shl;
    cur_dn = (33'(in_nrn.cur_i) + (33'sd1 <<< (shr - 4'd1))) >>> shr;
    if (cur_frac_r <= 5'd16) cur_nxt = sat32(66'(cur_up));
    else                     cur_nxt = sat32(66'(cur_dn));
  end

  logic               f1_vld_r, f2_vld_r;
  nrn_t               f1_r, f2_r;
  logic signed [63:0] sg_r;
  logic               sig_nz_r;

  // stage F2: noise add
  logic signed [64:0] nzr;
  logic signed [31:0] nz, isum;
  assign nzr  = (65'(sg_r) + 65'sd32768) >>> 16;
  assign nz   = sat32(66'(nzr));
  assign isum = sat32(66'(f1_r.cur_i) + 66'(nz));

  nrn_t f1_nxt, f2_nxt;
  always_comb begin
    f1_nxt       = in_nrn;
    f1_nxt.cur_i = cur_nxt;
    f2_nxt       = f1_r;
    f2_nxt.cur_i = sig_nz_r ? isum : f1_r.cur_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
      f2_vld_r <= 1'b0;
    end else if (en) begin
      f1_vld_r <= in_tvalid;
      f2_vld_r <= f1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_r     <= f1_nxt;
      sg_r     <= sigma * gs;
      sig_nz_r <= sigma != 32'sd0;
      f2_r     <= f2_nxt;
    end
  end

  // substeps
  logic [SUBSTEPS:0] ch_vld;
  nrn_t              ch_nrn [SUBSTEPS+1];
  assign ch_vld[0] = f2_vld_r;
  assign ch_nrn[0] = f2_r;

  for (genvar k = 0; k < SUBSTEPS; k++) begin : g_sub
    izh_substep u_sub (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .in_vld  (ch_vld[k]),
      .in_nrn  (ch_nrn[k]),
      .out_vld (ch_vld[k+1]),
      .out_nrn (ch_nrn[k+1])
    );
  end

  // output stage: forced fire, spike reset, history
  nrn_t               fin;
  logic               spk_nxt;
  logic signed [31:0] ud;
  assign fin     = ch_nrn[SUBSTEPS];
  assign spk_nxt = fin.fired | fin.force_fire;
  assign ud      = sat32(66'(fin.u) + 66'(fin.d));

  logic               out_vld_r;
  logic signed [31:0] v_out_r, u_out_r;
  logic               spk_r;
  logic [63:0]        hist_r;

  assign en = !out_vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ch_vld[SUBSTEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v_out_r <= spk_nxt ? fin.c : fin.v;
      u_out_r <= spk_nxt ? ud : fin.u;
      spk_r   <= spk_nxt;
      hist_r  <= {fin.hist[62:0], spk_nxt};
    end
  end

  assign in_tready  = en;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {7'd0, hist_r, spk_r, u_out_r, v_out_r};

endmodule
`default_nettype wire

[sv/izh_checker.sv]
// Port-level checks for the Izhikevich update block, bound to the top level.
// Depends on izh_pkg and izhikevich_neuron_update_top.
`default_nettype none
module izh_checker
  import izh_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata,
  input wire logic                  cfg_pready
);

  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_hist_bit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65] == out_tdata[64])
    else $error("history bit 0 differs from spike flag");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !(in_tvalid && in_tready))
    else $error("request taken while pipeline stalled");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("config port not ready");

endmodule

bind izhikevich_neuron_update_top izh_checker u_izh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .cfg_pready (cfg_pready)
);
`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for izhikevich_neuron_update_top.
// Streams neuron requests through the pipeline, predicts each update in SV and
// compares results field by field. Depends on izh_pkg and the RTL top.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import izh_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic signed [31:0] v, u, a, b, c, d, sigma, g, cur;
    logic               force_fire;
    logic [63:0]        hist;
  } neuron_req_t;

  typedef struct {
    logic signed [31:0] v, u;
    logic               spiked;
    logic [63:0]        hist;
  } neuron_upd_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  logic [31:0]           cfg_prdata;
  logic                  cfg_pready;

  neuron_upd_t expected_upd_q[$];
  logic [4:0]  cur_frac = CUR_FRAC_RESET;
  int          error_count = 0;
  int          idle_cycles = 0;
  bit          gaps_on = 1'b0;
  bit          stalls_on = 1'b0;
  int          stall_left = 0;

  izhikevich_neuron_update_top u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint sat_q(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint div_floor(longint x, longint dv);
    longint q;
    q = x / dv;
    if ((x % dv) != 0 && x < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint div_round(longint x, longint dv);
    return div_floor(x + dv / 2, dv);
  endfunction

  function automatic neuron_upd_t predict_update(neuron_req_t r, logic [4:0] fb);
    neuron_upd_t        o;
    longint             v, u, a, b, i_q, w, s, quad;
    longint unsigned    sq;
    logic               fired;
    v = r.v; u = r.u; a = r.a; b = r.b;
    fired = 1'b0;
    if (fb <= 16) i_q = sat_q(longint'(r.cur) * (64'sd1 <<< (16 - fb)));
    else          i_q = sat_q(div_round(longint'(r.cur), 64'sd1 <<< (fb - 16)));
    if (r.sigma != 0)
      i_q = sat_q(i_q + sat_q(div_round(longint'(r.sigma) * longint'(r.g), 65536)));
    for (int t = 0; t < SUBSTEPS; t++) begin
      if (!fired) begin
        sq   = longint'(v * v);
        quad = longint'((sq + 64'd819200) / 64'd1638400);
        s    = quad + 5 * v + 140 * 65536 - u + i_q;
        v    = sat_q(v + div_round(s, SUBSTEPS));
        w    = sat_q(div_round(b * v, 65536) - u);
        u    = sat_q(u + div_round(a * w, 65536 * SUBSTEPS));
        fired = (v >= 30 * 65536);
      end
    end
    fired = fired | r.force_fire;
    if (fired) begin
      v = r.c;
      u = sat_q(u + longint'(r.d));
    end
    o.v = v[31:0];
    o.u = u[31:0];
    o.spiked = fired;
    o.hist = {r.hist[62:0], fired};
    return o;
  endfunction

  // ---------------- result checker / stall / watchdog ----------------
  always @(posedge clk) begin
    neuron_upd_t e;
    if (out_tvalid && out_tready) begin
      if (expected_upd_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_tdata);
        error_count++;
      end else begin
        e = expected_upd_q.pop_front();
        if (out_tdata[31:0] !== e.v) begin
          $display("%0t: new_potential exp %h got %h", $time, e.v, out_tdata[31:0]);
          error_count++;
        end
        if (out_tdata[63:32] !== e.u) begin
          $display("%0t: new_recovery exp %h got %h", $time, e.u, out_tdata[63:32]);
          error_count++;
        end
        if (out_tdata[64] !== e.spiked) begin
          $display("%0t: spiked exp %b got %b", $time, e.spiked, out_tdata[64]);
          error_count++;
        end
        if (out_tdata[128:65] !== e.hist) begin
          $display("%0t: history_out exp %h got %h", $time, e.hist, out_tdata[128:65]);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    int r;
    if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70)      out_tready <= 1'b1;
      else if (r < 96) begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(0, 3);
      end else begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(10, 40);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL izhikevich_neuron_update_top");
      $finish;
    end
  end

  // ---------------- drivers ----------------
  task automatic send_neuron(neuron_req_t r);
    int g, p;
    g = 0;
    if (gaps_on) begin
      p = $urandom_range(0, 99);
      if (p < 60)      g = 0;
      else if (p < 95) g = $urandom_range(1, 3);
      else             g = $urandom_range(10, 40);
    end
    if (g > 0) begin
      in_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, r.hist, r.force_fire, r.cur, r.g, r.sigma,
                  r.d, r.c, r.b, r.a, r.u, r.v};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_upd_q.push_back(predict_update(r, cur_frac));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_upd_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_cur_frac(logic [4:0] val);
    wait_drained();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_ADDR_W'(REG_CUR_FRAC) << 2;
    cfg_pwdata  <= {27'b0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cur_frac = val;
  endtask

  // ---------------- stimulus helpers ----------------
  function automatic logic signed [31:0] q_range(int lo, int hi);
    return $signed($urandom_range(0, (hi - lo) * 65536)) + lo * 65536;
  endfunction

  function automatic logic signed [31:0] q_wild(int lo, int hi);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 32'sh7fff_ffff;
    if (r == 1) return 32'sh8000_0000;
    if (r < 5)  return $urandom;
    return q_range(lo, hi);
  endfunction

  function automatic neuron_req_t regular_neuron();
    neuron_req_t r;
    r.v = q_range(-80, -50);
    r.u = q_range(-20, 0);
    r.a = 32'sd1311;   // 0.02
    r.b = 32'sd13107;  // 0.2
    r.c = -32'sd4259840;
    r.d = 32'sd524288;
    r.sigma = 0;
    r.g = 0;
    r.cur = 0;
    r.force_fire = 1'b0;
    r.hist = 64'h0;
    return r;
  endfunction

  function automatic neuron_req_t random_neuron();
    neuron_req_t r;
    r.v = q_wild(-90, 40);
    r.u = q_wild(-30, 30);
    r.a = ($urandom_range(0, 4) == 0) ? q_wild(-1, 1) : $signed($urandom_range(0, 13107));
    r.b = ($urandom_range(0, 4) == 0) ? q_wild(-1, 1) : $signed($urandom_range(0, 19661));
    r.c = q_wild(-70, -40);
    r.d = q_wild(0, 10);
    r.sigma = ($urandom_range(0, 2) == 0) ? 32'sd0 : q_wild(0, 5);
    r.g = q_wild(-4, 4);
    if ($urandom_range(0, 4) == 0)
      r.cur = $urandom;
    else if (cur_frac <= 26)
      r.cur = $signed($urandom_range(0, 20 << cur_frac));
    else
      r.cur = $urandom;
    r.force_fire = ($urandom_range(0, 9) == 0);
    r.hist = {$urandom, $urandom};
    return r;
  endfunction

  function automatic neuron_req_t random_neuron_ok();
    neuron_req_t r;
    r = regular_neuron();
    r.v = q_range(-80, 35);
    r.sigma = ($urandom_range(0, 1) == 0) ? 32'sd0 : q_range(0, 3);
    r.g = q_range(-3, 3);
    r.cur = (cur_frac <= 26) ? $signed($urandom_range(0, 15 << cur_frac)) : $urandom;
    r.force_fire = ($urandom_range(0, 19) == 0);
    r.hist = {$urandom, $urandom};
    return r;
  endfunction

  // ---------------- tests ----------------
  task automatic test_directed();
    neuron_req_t r;
    r = regular_neuron(); send_neuron(r);
    r.cur = 32'sd10 <<< 20; send_neuron(r);
    r.v = 32'sd1900000; r.cur = 32'sd20 <<< 20; send_neuron(r);
    r = regular_neuron(); r.force_fire = 1'b1; r.hist = '1; send_neuron(r);
    r = regular_neuron(); r.sigma = 32'sd65536; r.g = 32'sd131072; send_neuron(r);
    r.sigma = 32'sh7fff_ffff; r.g = 32'sh7fff_ffff; send_neuron(r);
    r.sigma = 32'sh8000_0000; r.g = 32'sh7fff_ffff; send_neuron(r);
    r.sigma = 32'sh8000_0000; r.g = 32'sh8000_0000; send_neuron(r);
    r = regular_neuron(); r.v = 32'sh7fff_ffff; send_neuron(r);
    r.v = 32'sh8000_0000; send_neuron(r);
    r.u = 32'sh7fff_ffff; send_neuron(r);
    r.u = 32'sh8000_0000; r.v = 0; send_neuron(r);
    r = regular_neuron(); r.a = 32'sh7fff_ffff; r.b = 32'sh8000_0000; send_neuron(r);
    r.a = 32'sh8000_0000; r.b = 32'sh7fff_ffff; send_neuron(r);
    r = regular_neuron(); r.cur = 32'sh7fff_ffff; send_neuron(r);
    r.cur = 32'sh8000_0000; send_neuron(r);
    r = regular_neuron(); r.force_fire = 1'b1; r.c = 32'sh8000_0000;
    r.d = 32'sh7fff_ffff; r.u = 32'sh7fff_0000; send_neuron(r);
    r.c = 32'sh7fff_ffff; r.d = 32'sh8000_0000; r.u = 32'sh8000_0000; send_neuron(r);
    r.hist = 64'h8000_0000_0000_0001; send_neuron(r);
    r = regular_neuron(); r.hist = 64'haaaa_5555_aaaa_5555; send_neuron(r);
  endtask

  task automatic test_frac_extremes();
    logic [4:0] settings[5] = '{5'd0, 5'd31, 5'd16, 5'd17, 5'd1};
    neuron_req_t r;
    foreach (settings[k]) begin
      write_cur_frac(settings[k]);
      r = regular_neuron();
      r.cur = 32'sh7fff_ffff; send_neuron(r);
      r.cur = 32'sh8000_0000; send_neuron(r);
      r.cur = 32'sd3;         send_neuron(r);
      r.cur = -32'sd3;        send_neuron(r);
    end
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 14; ph++) begin
      gaps_on   = (ph % 4 != 1);
      stalls_on = (ph % 4 != 2);
      if (ph == 0)       write_cur_frac(5'd0);
      else if (ph == 1)  write_cur_frac(5'd31);
      else if (ph == 2)  write_cur_frac(CUR_FRAC_RESET);
      else               write_cur_frac(5'($urandom_range(0, 31)));
      for (int n = 0; n < 100; n++) begin
        if (n == 50) wait_drained();
        send_neuron(($urandom_range(0, 3) == 0) ? random_neuron() : random_neuron_ok());
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_frac_extremes();
    test_random_traffic();
    wait_drained();
    repeat (40) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS izhikevich_neuron_update_top");
    end else begin
      $display("FAIL izhikevich_neuron_update_top");
    end
    $finish;
  end

endmodule
`default_nettype wire
